/* hw/rtl/drf_pkg.sv */
// Shared types and constants for the decimal readout formatter.
package drf_pkg;

	localparam int DISPLAY_PLACES_DEF = 8;

	localparam int VALUE_W = 27;
	localparam int POS_W = 3;
	localparam int CHAR_W = 6;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
	localparam int FILL_LOW_PLACE = 2;

	// Divide by ten: q = (x * RECIP) >> RECIP_SHIFT, exact for x < 2**34.
	localparam int RECIP_W = 32;
	localparam int RECIP_SHIFT = 35;
	localparam logic [RECIP_W-1:0] RECIP = 32'd3435973837;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic                 valid;
		logic [VALUE_W-1:0]   value;
	} head_t;

endpackage

/* hw/rtl/decimal_readout_formatter_top.sv */
// Top level of the decimal readout formatter.
//
//  channel  dir  tdata                         tlast
//  s_*      in   [26:0] value, zero pad to 32  -
//  m_*      out  [2:0] position, [8:3] char    last write of the value
//
// A value gives n writes, n = max(digit count, DISPLAY_PLACES-2), capped at
// DISPLAY_PLACES; one write per cycle while the output is not stalled, from
// the divide-by-ten step in the digit engine.
// The next value loads in the cycle of the previous value's last write.
// A two-entry queue keeps taking values while the output is stalled, until full.
// Reset clears queue and engine control; no items are held across it.
module decimal_readout_formatter_top #(
	parameter int DISPLAY_PLACES = drf_pkg::DISPLAY_PLACES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [drf_pkg::S_TDATA_W-1:0] s_tdata,  // [26:0] value
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [drf_pkg::M_TDATA_W-1:0] m_tdata,  // [2:0] position, [8:3] character
	output logic                          m_tlast
);

	drf_pkg::head_t head;
	logic pop;

	drf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.head     (head),
		.pop      (pop)
	);

	drf_back #(
		.DISPLAY_PLACES (DISPLAY_PLACES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* hw/rtl/drf_front.sv */
// Input side: accepts value items into a short queue for the digit engine.
module drf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [drf_pkg::S_TDATA_W-1:0] s_tdata,
	output drf_pkg::head_t                head,
	input  logic                          pop
);

	logic [drf_pkg::VALUE_W-1:0] mem [drf_pkg::QUEUE_DEPTH];
	logic [drf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [drf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [drf_pkg::QCNT_W-1:0] count_q;
	logic push;
	logic do_pop;

	assign s_tready = (count_q != drf_pkg::QCNT_W'(drf_pkg::QUEUE_DEPTH));
	assign push = s_tvalid && s_tready;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.value = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= s_tdata[drf_pkg::VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/drf_back.sv */
// Digit engine: one divide-by-ten step and one character write per cycle while the output is not stalled.
module drf_back #(
	parameter int DISPLAY_PLACES = drf_pkg::DISPLAY_PLACES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  drf_pkg::head_t                head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [drf_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	localparam int PLACE_W = $clog2(DISPLAY_PLACES);
	localparam int PROD_W = drf_pkg::VALUE_W + drf_pkg::RECIP_W;

	logic                          busy_q;
	logic [drf_pkg::VALUE_W-1:0]   rest_q;
	logic [PLACE_W-1:0]            place_q;
	logic                          out_valid_q;
	logic [drf_pkg::POS_W-1:0]     pos_q;
	logic [drf_pkg::CHAR_W-1:0]    char_q;
	logic                          last_q;

	logic                          emit;
	logic                          more;
	logic                          load;
	logic [PROD_W-1:0]             prod;
	logic [drf_pkg::VALUE_W-1:0]   quot;
	logic [drf_pkg::VALUE_W-1:0]   rem_w;
	logic [3:0]                    digit;

	assign emit = busy_q && (!out_valid_q || m_tready);

	// Fill phase has rest zero, so quotient and digit come out zero too.
	assign prod = {{drf_pkg::RECIP_W{1'b0}}, rest_q} * {{drf_pkg::VALUE_W{1'b0}}, drf_pkg::RECIP};
	assign quot = drf_pkg::VALUE_W'(prod >> drf_pkg::RECIP_SHIFT);
	assign rem_w = rest_q - ((quot << 3) + (quot << 1));
	assign digit = rem_w[3:0];

	// Another write follows if a place is left and either digits remain
	// or the zero fill has not yet reached its lowest place.
	assign more = (place_q != '0) &&
		((quot != '0) || (place_q >= PLACE_W'(drf_pkg::FILL_LOW_PLACE + 1)));

	assign load = head.valid && (!busy_q || (emit && !more));
	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit) begin
				busy_q <= more;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rest_q <= head.value;
			place_q <= PLACE_W'(DISPLAY_PLACES - 1);
		end else if (emit) begin
			rest_q <= quot;
			place_q <= place_q - 1'b1;
		end
		if (emit) begin
			pos_q <= drf_pkg::POS_W'(place_q);
			char_q <= drf_pkg::ASCII_ZERO + drf_pkg::CHAR_W'(digit);
			last_q <= !more;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(drf_pkg::M_TDATA_W - drf_pkg::POS_W - drf_pkg::CHAR_W){1'b0}},
		char_q, pos_q};
	assign m_tlast = last_q;

endmodule

/* hw/rtl/drf_checker.sv */
// Port-level checks for the decimal readout formatter, bound to the top level.
module drf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [drf_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:3] >= 6'd48) && (m_tdata[8:3] <= 6'd57)
			&& (m_tdata[15:9] == 7'd0))
		else $error("character outside decimal digits");

	a_last_place: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[2:0] <= 3'd2))
		else $error("last write above lowest fill place");

	// Checked with a non-overlapping implication: the first reset edge may still see unset flops.
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during or right after reset");

endmodule

bind decimal_readout_formatter_top drf_checker u_drf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
